/* sv/apps_pkg.sv */
// shared types and codes of the arm pick-and-place sequencer
`timescale 1ns / 1ps

package apps_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_GO_SQUARE  = 3'd1,
    OP_GRAB       = 3'd2,
    OP_RELEASE    = 3'd3,
    OP_GO_HOME    = 3'd4,
    OP_GO_DISCARD = 3'd5,
    OP_WRITE_POS  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CFG_VSTEP = 3'd0,
    CFG_HSTEP = 3'd1,
    CFG_FREE  = 3'd2,
    CFG_BOARD = 3'd3,
    CFG_MWAIT = 3'd4,
    CFG_GWAIT = 3'd5
  } cfg_idx_t;

  localparam int STEP_W = 12;
  localparam int HGT_W  = 16;
  localparam int TICK_W = 16;
  localparam int CFG_W  = 16;
  localparam int ADDR9  = 9;

  // decoded command handed to the sequencer core
  typedef struct packed {
    op_t  op;
    logic sq_bad;
  } cmd_t;

  // core stage status seen by the top level
  typedef struct packed {
    logic busy;
    logic fire;
  } stage_stat_t;

endpackage

/* sv/apps_if.sv */
// command and result channel interfaces
`timescale 1ns / 1ps

interface apps_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    operation;
  logic [3:0]                    square_col;
  logic [3:0]                    square_row;
  logic [6:0]                    slot_index;
  logic signed [COORD_WIDTH-1:0] slot_x;
  logic signed [COORD_WIDTH-1:0] slot_y;

  modport source (output valid, operation, square_col, square_row, slot_index, slot_x,
                  slot_y, input ready);
  modport sink (input valid, operation, square_col, square_row, slot_index, slot_x,
                slot_y, output ready);
endinterface

interface apps_out_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    result_kind;
  logic signed [COORD_WIDTH-1:0] arm_x;
  logic signed [COORD_WIDTH-1:0] arm_y;
  logic signed [COORD_WIDTH-1:0] arm_z;

  modport source (output valid, result_kind, arm_x, arm_y, arm_z, input ready);
  modport sink (input valid, result_kind, arm_x, arm_y, arm_z, output ready);
endinterface

/* sv/apps_table.sv */
// position table memory with per-slot valid bits cleared at reset
`timescale 1ns / 1ps

module apps_table #(
  parameter int SLOTS  = 66,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  valid_r;
  logic [DATA_W-1:0] rd_raw_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // a slot never written reads as zero
  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

/* sv/apps_core.sv */
// sequencer core: command stage, arm state, config registers and result register
`timescale 1ns / 1ps

module apps_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  apps_pkg::cmd_t                cmd,
  input  logic signed [COORD_WIDTH-1:0] rd_x,
  input  logic signed [COORD_WIDTH-1:0] rd_y,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [apps_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output apps_pkg::kind_t               out_kind,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output apps_pkg::stage_stat_t         stat
);

  // positions carry the wider of coordinate and height widths, math two bits more
  localparam int PW = (COORD_WIDTH > apps_pkg::HGT_W) ? COORD_WIDTH : apps_pkg::HGT_W;
  localparam int AW = PW + 2;

  typedef enum logic [1:0] {M_IDLE, M_MOVE, M_CONTROL, M_WAIT} mode_t;
  typedef enum logic [1:0] {C_IDLE, C_GRAB, C_RELEASE} ctl_t;
  typedef enum logic [1:0] {P_IDLE, P_DOWN, P_GRIP, P_UP} phase_t;

  logic                               s1_valid_r;
  apps_pkg::cmd_t                     s1_cmd_r;
  logic                               fire;

  logic [apps_pkg::STEP_W-1:0]        vstep_r, hstep_r;
  logic signed [apps_pkg::HGT_W-1:0]  free_h_r, board_h_r;
  logic [apps_pkg::TICK_W-1:0]        mwait_r, gwait_r;

  mode_t                              mode_r, mode_nxt;
  ctl_t                               ctl_r, ctl_nxt;
  phase_t                             phase_r, phase_nxt;
  logic signed [PW-1:0]               cur_r [3];
  logic signed [PW-1:0]               cur_nxt [3];
  logic signed [PW-1:0]               tgt_r [3];
  logic signed [PW-1:0]               tgt_nxt [3];
  logic [apps_pkg::TICK_W-1:0]        wait_r, wait_nxt;

  logic                               res;
  apps_pkg::kind_t                    res_kind;
  logic                               res_move;
  logic                               out_valid_r;
  apps_pkg::kind_t                    out_kind_r;
  logic signed [COORD_WIDTH-1:0]      out_x_r, out_y_r, out_z_r;

  function automatic logic signed [PW-1:0] step_axis(
    input logic signed [PW-1:0]       cur,
    input logic signed [PW-1:0]       tgt,
    input logic [apps_pkg::STEP_W-1:0] stp
  );
    logic signed [AW-1:0] c;
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] r;
    c = AW'(cur);
    t = AW'(tgt);
    s = $signed({{(AW - apps_pkg::STEP_W){1'b0}}, stp});
    if (c < t) begin
      r = c + s;
      if (r >= t) r = t;
    end else begin
      r = c - s;
      if (r <= t) r = t;
    end
    return PW'(r);
  endfunction

  assign fire = s1_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    mode_nxt  = mode_r;
    ctl_nxt   = ctl_r;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    for (int i = 0; i < 3; i++) begin
      cur_nxt[i] = cur_r[i];
      tgt_nxt[i] = tgt_r[i];
    end
    res      = 1'b0;
    res_kind = apps_pkg::KIND_DONE;
    res_move = 1'b0;
    if (fire) begin
      case (s1_cmd_r.op)
        apps_pkg::OP_TICK: begin
          case (mode_r)
            M_MOVE: begin
              cur_nxt[0] = step_axis(cur_r[0], tgt_r[0], hstep_r);
              cur_nxt[1] = step_axis(cur_r[1], tgt_r[1], hstep_r);
              cur_nxt[2] = step_axis(cur_r[2], tgt_r[2], vstep_r);
              res        = 1'b1;
              res_kind   = apps_pkg::KIND_MOVE;
              res_move   = 1'b1;
              mode_nxt   = M_WAIT;
              wait_nxt   = mwait_r;
            end
            M_WAIT: begin
              if (wait_r != '0) begin
                wait_nxt = wait_r - 1'b1;
              end else if (cur_r[0] == tgt_r[0] && cur_r[1] == tgt_r[1] &&
                           cur_r[2] == tgt_r[2]) begin
                mode_nxt = M_CONTROL;
              end else begin
                mode_nxt = M_MOVE;
              end
            end
            M_CONTROL: begin
              if (ctl_r != C_GRAB && ctl_r != C_RELEASE) begin
                mode_nxt = M_IDLE;
                res      = 1'b1;
                res_kind = apps_pkg::KIND_DONE;
              end else begin
                case (phase_r)
                  P_IDLE: begin
                    tgt_nxt[2] = PW'(board_h_r);
                    phase_nxt  = P_DOWN;
                    mode_nxt   = M_MOVE;
                  end
                  P_DOWN: begin
                    res       = 1'b1;
                    res_kind  = (ctl_r == C_GRAB) ? apps_pkg::KIND_CLOSE
                                                  : apps_pkg::KIND_OPEN;
                    mode_nxt  = M_WAIT;
                    wait_nxt  = gwait_r;
                    phase_nxt = P_GRIP;
                  end
                  P_GRIP: begin
                    tgt_nxt[2] = PW'(free_h_r);
                    phase_nxt  = P_UP;
                    mode_nxt   = M_MOVE;
                  end
                  default: begin
                    phase_nxt = P_IDLE;
                    ctl_nxt   = C_IDLE;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
        apps_pkg::OP_GO_SQUARE: begin
          if (s1_cmd_r.sq_bad || (rd_x == '0 && rd_y == '0)) begin
            res      = 1'b1;
            res_kind = apps_pkg::KIND_ERROR;
          end else begin
            tgt_nxt[0] = PW'(rd_x);
            tgt_nxt[1] = PW'(rd_y);
            tgt_nxt[2] = PW'(free_h_r);
            mode_nxt   = M_MOVE;
          end
        end
        apps_pkg::OP_GRAB: begin
          mode_nxt = M_CONTROL;
          ctl_nxt  = C_GRAB;
        end
        apps_pkg::OP_RELEASE: begin
          mode_nxt = M_CONTROL;
          ctl_nxt  = C_RELEASE;
        end
        apps_pkg::OP_GO_HOME, apps_pkg::OP_GO_DISCARD: begin
          // home and discard skip the loaded check
          tgt_nxt[0] = PW'(rd_x);
          tgt_nxt[1] = PW'(rd_y);
          tgt_nxt[2] = PW'(free_h_r);
          mode_nxt   = M_MOVE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      vstep_r     <= apps_pkg::STEP_W'(1);
      hstep_r     <= apps_pkg::STEP_W'(1);
      free_h_r    <= '0;
      board_h_r   <= '0;
      mwait_r     <= apps_pkg::TICK_W'(1);
      gwait_r     <= apps_pkg::TICK_W'(1);
      mode_r      <= M_IDLE;
      ctl_r       <= C_IDLE;
      phase_r     <= P_IDLE;
      wait_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_cmd_r   <= cmd;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (apps_pkg::cfg_idx_t'(cfg_index))
          apps_pkg::CFG_VSTEP: vstep_r   <= cfg_wdata[apps_pkg::STEP_W-1:0];
          apps_pkg::CFG_HSTEP: hstep_r   <= cfg_wdata[apps_pkg::STEP_W-1:0];
          apps_pkg::CFG_FREE:  free_h_r  <= $signed(cfg_wdata[apps_pkg::HGT_W-1:0]);
          apps_pkg::CFG_BOARD: board_h_r <= $signed(cfg_wdata[apps_pkg::HGT_W-1:0]);
          apps_pkg::CFG_MWAIT: mwait_r   <= cfg_wdata[apps_pkg::TICK_W-1:0];
          apps_pkg::CFG_GWAIT: gwait_r   <= cfg_wdata[apps_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      mode_r  <= mode_nxt;
      ctl_r   <= ctl_nxt;
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= cur_nxt[i];
        tgt_r[i] <= tgt_nxt[i];
      end
      if (fire && res) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= res_kind;
        out_x_r     <= res_move ? COORD_WIDTH'(cur_nxt[0]) : '0;
        out_y_r     <= res_move ? COORD_WIDTH'(cur_nxt[1]) : '0;
        out_z_r     <= res_move ? COORD_WIDTH'(cur_nxt[2]) : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign stat.busy = s1_valid_r;
  assign stat.fire = fire;

endmodule

/* sv/arm_pick_place_sequencer.sv */
// top level of the arm pick-and-place sequencer
`timescale 1ns / 1ps

// Takes one command or tick word per cycle while results are taken and gives at
// most one result word per word, in order. A word is accepted and its position
// table slot is read from the table memory at the same edge. The word is executed
// against the arm state, and the result register loaded, when the command stage
// fires; a stalled result register holds the word there. Table writes go through
// the separate write port at the accepting edge, so a go-to command right after a
// write sees the new entry. Throughput is one word per cycle while results are
// taken; the one command stage holds a word while the result register is stalled.
// Reset clears the table at once through per-slot valid bits, with no clearing pass.
// Configuration writes take effect on the edge after cfg_we.

module arm_pick_place_sequencer #(
  parameter int BOARD_SIDE  = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  apps_in_if.sink                    in_if,
  apps_out_if.source                 out_if,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [apps_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int SQUARES = BOARD_SIDE * BOARD_SIDE;
  localparam int SLOTS   = SQUARES + 2;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int DATA_W  = 2 * COORD_WIDTH;

  logic                          in_fire;
  apps_pkg::cmd_t                cmd;
  apps_pkg::stage_stat_t         core_stat;
  logic [apps_pkg::ADDR9-1:0]    sq_addr9;
  logic [apps_pkg::ADDR9-1:0]    rd_addr9;
  logic [apps_pkg::ADDR9-1:0]    slot9;
  logic                          tbl_we;
  logic [DATA_W-1:0]             rd_data;
  apps_pkg::kind_t               out_kind;

  assign in_fire     = in_if.valid && in_if.ready;
  assign in_if.ready = !core_stat.busy || core_stat.fire;

  assign cmd.op     = apps_pkg::op_t'(in_if.operation);
  assign cmd.sq_bad = ({1'b0, in_if.square_col} >= 5'(BOARD_SIDE)) ||
                      ({1'b0, in_if.square_row} >= 5'(BOARD_SIDE));

  assign sq_addr9 = cmd.sq_bad ? '0
                  : apps_pkg::ADDR9'(in_if.square_col) * apps_pkg::ADDR9'(BOARD_SIDE)
                    + apps_pkg::ADDR9'(in_if.square_row);

  always_comb begin
    case (cmd.op)
      apps_pkg::OP_GO_HOME:    rd_addr9 = apps_pkg::ADDR9'(SQUARES);
      apps_pkg::OP_GO_DISCARD: rd_addr9 = apps_pkg::ADDR9'(SQUARES + 1);
      default:                 rd_addr9 = sq_addr9;
    endcase
  end

  assign slot9  = apps_pkg::ADDR9'(in_if.slot_index);
  // writes beyond the last slot are dropped
  assign tbl_we = in_fire && cmd.op == apps_pkg::OP_WRITE_POS &&
                  slot9 < apps_pkg::ADDR9'(SLOTS);

  apps_table #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (slot9[ADDR_W-1:0]),
    .wr_data ({in_if.slot_x, in_if.slot_y}),
    .rd_en   (in_fire),
    .rd_addr (rd_addr9[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  apps_core #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cmd       (cmd),
    .rd_x      ($signed(rd_data[DATA_W-1:COORD_WIDTH])),
    .rd_y      ($signed(rd_data[COORD_WIDTH-1:0])),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_kind  (out_kind),
    .out_x     (out_if.arm_x),
    .out_y     (out_if.arm_y),
    .out_z     (out_if.arm_z),
    .stat      (core_stat)
  );

  assign out_if.result_kind = out_kind;

`ifndef SYNTHESIS
  // a held word must block new input while the result register is stalled
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (core_stat.busy && out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while command stage is stalled");

  // only arm moves carry coordinates
  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_kind != apps_pkg::KIND_MOVE) |->
    (out_if.arm_x == '0 && out_if.arm_y == '0 && out_if.arm_z == '0))
    else $error("non-move result with nonzero coordinates");

  // a new result only follows execution of a word
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(core_stat.fire))
    else $error("result appeared without an executed word");
`endif

endmodule
